// ===== hw/rtl/arrl_pkg.sv =====
// ============================================================================
// Address range remap lookup: shared package
// Item types, command and status codes, the table record layout and the
// helper that builds a result item.
// ============================================================================
package arrl_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;

   // Command codes carried in the request item.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   // Status codes carried in the result item.
   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_MISS_NEXT = 3'd1;
   localparam logic [2:0] ST_MISS_NONE = 3'd2;
   localparam logic [2:0] ST_ADDED     = 3'd3;
   localparam logic [2:0] ST_REJECTED  = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] address;
      logic [31:0] range_size;
      logic [31:0] source_start;
      logic [31:0] source_size;
   } arrl_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  entry_index;
      logic [31:0] found_new_start;
      logic [31:0] found_new_size;
      logic [31:0] found_old_start;
      logic [31:0] found_old_size;
   } arrl_rsp_type;

   // One table record as it is held in the record memory.
   typedef struct packed {
      logic [31:0] new_start;
      logic [31:0] new_size;
      logic [31:0] old_start;
      logic [31:0] old_size;
   } arrl_rec_type;

   localparam int REC_WIDTH = $bits(arrl_rec_type);

   // Flags from the shared range comparator.
   typedef struct packed {
      logic lt_base;
      logic ge_end;
   } arrl_cmp_type;

   function automatic arrl_rsp_type make_rsp(input logic [2:0]   status,
                                             input logic [31:0]  index,
                                             input arrl_rec_type rec);
      arrl_rsp_type r;
      r.status          = status;
      r.entry_index     = index[9:0];
      r.found_new_start = rec.new_start;
      r.found_new_size  = rec.new_size;
      r.found_old_start = rec.old_start;
      r.found_old_size  = rec.old_size;
      return r;
   endfunction

endpackage

// ===== hw/rtl/arrl_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module arrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/arrl_cmp.sv =====
// ============================================================================
// Shared range comparator
// Compares a key against a 33-bit base and against base plus size, the
// range end being formed in 33 bits so that it never wraps.
// ============================================================================
module arrl_cmp (
   input  logic [31:0]           key,
   input  logic [32:0]           base,
   input  logic [31:0]           size,
   output arrl_pkg::arrl_cmp_type flags
);

   logic [32:0] key_wide;
   logic [32:0] range_end;

   assign key_wide      = {1'b0, key};
   assign range_end     = base + {1'b0, size};
   assign flags.lt_base = key_wide < base;
   assign flags.ge_end  = key_wide >= range_end;

endmodule

// ===== hw/rtl/address_range_remap_lookup.sv =====
// ============================================================================
// Address range remap lookup
// Holds a table of remap records in ascending order of new start, appends
// records, clears the table and binary-searches it for an address.
// ============================================================================
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_data (arrl_req_type)
//   rsp      out        rsp_valid/rsp_ready  rsp_data (arrl_rsp_type)
//
// A clear, an add or an unused command is accepted in the idle state and
// executed in the execute state, at the end of which the result is in
// the output register when that is free. A lookup adds a compare step per
// probe of the binary search (at most ceil(log2(count + 1)) probes), plus
// a fetch step when the next record above the address is fetched. The pace
// is set by the single read port of the record memory and its registered
// read data, which the comparator consumes one probe per cycle.
// Reset is synchronous and empties the table; the record memory itself is
// not cleared, since only entries below the record count are ever read.
// One item is worked on at a time. A finished result waits in the output
// register, and the next item is taken while it waits; should a second
// result be ready before the first is taken, it is parked and the block
// holds off further items until the output register frees up.
//
module address_range_remap_lookup #(
   parameter int TABLE_DEPTH = arrl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  arrl_pkg::arrl_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output arrl_pkg::arrl_rsp_type rsp_data
);

   // Index width addresses a record; count width also holds the full depth.
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_CMP,
      S_FETCH,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   arrl_pkg::arrl_req_type item_ff, item_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [32:0]            last_end_ff, last_end_in;
   logic [CW-1:0]          lo_ff, lo_in;
   logic [CW-1:0]          hi_ff, hi_in;
   logic [IW-1:0]          mid_ff, mid_in;
   arrl_pkg::arrl_rsp_type park_ff, park_in;
   arrl_pkg::arrl_rsp_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Record memory signals.
   logic                           wr_en;
   logic [IW-1:0]                  rd_addr;
   logic [arrl_pkg::REC_WIDTH-1:0] rd_data;
   arrl_pkg::arrl_rec_type         rec;
   arrl_pkg::arrl_rec_type         new_rec;

   // Comparator operands and flags.
   logic [32:0]            cmp_base;
   logic [31:0]            cmp_size;
   arrl_pkg::arrl_cmp_type cmp_flags;

   // Search bookkeeping.
   logic [CW-1:0] lo_nx;
   logic [CW-1:0] hi_nx;
   logic [CW:0]   sum_first;
   logic [CW:0]   sum_nx;
   logic [IW-1:0] mid_first;
   logic [IW-1:0] mid_nx;
   logic [32:0]   new_end;

   logic                   out_free;
   logic                   fin;
   arrl_pkg::arrl_rsp_type res;

   assign new_rec.new_start = item_ff.address;
   assign new_rec.new_size  = item_ff.range_size;
   assign new_rec.old_start = item_ff.source_start;
   assign new_rec.old_size  = item_ff.source_size;
   assign rec               = rd_data;

   arrl_ram #(
      .WIDTH (arrl_pkg::REC_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (new_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // While an add is executed the comparator checks the new start against
   // the end of the last record; during the search it tests the probed
   // record's range.
   always_comb begin
      if (state_ff == S_EXEC) begin
         cmp_base = last_end_ff;
         cmp_size = '0;
      end else begin
         cmp_base = {1'b0, rec.new_start};
         cmp_size = rec.new_size;
      end
   end

   arrl_cmp u_cmp (
      .key   (item_ff.address),
      .base  (cmp_base),
      .size  (cmp_size),
      .flags (cmp_flags)
   );

   assign new_end   = {1'b0, item_ff.address} + {1'b0, item_ff.range_size};
   assign sum_first = {1'b0, count_ff};
   assign mid_first = sum_first[IW:1];

   // Narrow the search window from the probe that has just been read.
   always_comb begin
      lo_nx = lo_ff;
      hi_nx = hi_ff;
      if (cmp_flags.lt_base) begin
         hi_nx = CW'(mid_ff);
      end else if (cmp_flags.ge_end) begin
         lo_nx = CW'(mid_ff) + CW'(1);
      end
   end

   assign sum_nx = {1'b0, lo_nx} + {1'b0, hi_nx};
   assign mid_nx = sum_nx[IW:1];

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      last_end_in  = last_end_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      park_in      = park_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      rd_addr      = mid_ff;
      fin          = 1'b0;
      res          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (item_ff.command)
               arrl_pkg::CMD_CLEAR: begin
                  count_in    = '0;
                  last_end_in = '0;
                  fin         = 1'b1;
                  res         = arrl_pkg::make_rsp(arrl_pkg::ST_CLEARED, '0, '0);
               end
               arrl_pkg::CMD_ADD: begin
                  fin = 1'b1;
                  if (count_ff == DEPTH_C || cmp_flags.lt_base) begin
                     res = arrl_pkg::make_rsp(arrl_pkg::ST_REJECTED, '0, '0);
                  end else begin
                     wr_en       = 1'b1;
                     count_in    = count_ff + CW'(1);
                     last_end_in = new_end;
                     res = arrl_pkg::make_rsp(arrl_pkg::ST_ADDED, 32'(count_ff), new_rec);
                  end
               end
               arrl_pkg::CMD_LOOKUP: begin
                  if (count_ff == '0) begin
                     fin = 1'b1;
                     res = arrl_pkg::make_rsp(arrl_pkg::ST_MISS_NONE, '0, '0);
                  end else begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     mid_in   = mid_first;
                     rd_addr  = mid_first;
                     state_in = S_CMP;
                  end
               end
               default: begin
                  fin = 1'b1;
                  res = arrl_pkg::make_rsp(arrl_pkg::ST_REJECTED, '0, '0);
               end
            endcase
         end
         S_CMP: begin
            if (!cmp_flags.lt_base && !cmp_flags.ge_end) begin
               fin = 1'b1;
               res = arrl_pkg::make_rsp(arrl_pkg::ST_HIT, 32'(mid_ff), rec);
            end else if (lo_nx < hi_nx) begin
               lo_in   = lo_nx;
               hi_in   = hi_nx;
               mid_in  = mid_nx;
               rd_addr = mid_nx;
            end else if (lo_nx < count_ff) begin
               // The search ended between records: fetch the one above.
               mid_in   = lo_nx[IW-1:0];
               rd_addr  = lo_nx[IW-1:0];
               state_in = S_FETCH;
            end else begin
               fin = 1'b1;
               res = arrl_pkg::make_rsp(arrl_pkg::ST_MISS_NONE, '0, '0);
            end
         end
         S_FETCH: begin
            fin = 1'b1;
            res = arrl_pkg::make_rsp(arrl_pkg::ST_MISS_NEXT, 32'(mid_ff), rec);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in       = park_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A finished result goes straight to the output register when it is
      // free, and is parked otherwise.
      if (fin) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            park_in  = res;
            state_in = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         last_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_end_ff  <= last_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      park_ff <= park_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The record count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("record count beyond table depth");

   // A probe is only made inside a non-empty window of stored records.
   a_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> (lo_ff < hi_ff) && (hi_ff <= count_ff)
         && (CW'(mid_ff) >= lo_ff) && (CW'(mid_ff) < hi_ff))
      else $error("search window is empty or out of range");

   // A result is parked only while the output register is still occupied.
   a_park: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> rsp_valid_ff)
      else $error("parked result with a free output register");

   // The next record returned on a miss is a stored one.
   a_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> CW'(mid_ff) < count_ff)
      else $error("fetch of a record beyond the count");

   // An accepted add grows the table by exactly one record.
   a_add: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("add did not advance the record count");

endmodule
